/* hdl/rhm_pkg.sv */
// Shared constants, state types and controller/datapath interface structs for the median line.
package rhm_pkg;

  localparam int PIX_W                = 8;
  localparam int NUM_BINS             = 256;
  localparam int COL_W                = 12;
  localparam int HW_W                 = 3;
  localparam logic [HW_W-1:0] HW_RESET = 3'd1;
  localparam int DEF_MAX_HALF_WINDOW  = 7;
  localparam int DEF_MAX_LINE_WIDTH   = 4096;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PR,
    S_PH,
    S_PW,
    S_WRD,
    S_WUC,
    S_WUF,
    S_WDC,
    S_WDF,
    S_EMIT,
    S_COLDONE,
    S_EOL,
    S_FLNEXT,
    S_ERR,
    S_CLEAR
  } state_t;

  typedef enum logic {
    MODE_ADD,
    MODE_PROD
  } mode_t;

  typedef struct packed {
    logic accept;
    logic setup_col;
    logic col_done;
    logic setup_flush;
    logic flush_next;
    logic op_rem;
    logic ring_rd;
    logic hist_rd;
    logic pix_wr;
    logic rep_dec;
    logic walk_rd;
    logic up_step;
    logic up_fin;
    logic dn_step;
    logic dn_fin;
    logic emit_med;
    logic line_done;
    logic emit_err;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic c_lt_k;
    logic last_row;
    logic rep_zero;
    logic up_go;
    logic dn_go;
    logic out_free;
    logic cols_short;
    logic k_zero;
    logic flush_last;
  } status_t;

endpackage

/* hdl/running_histogram_median_line.sv */
// A pixel that does not finish a column is accepted straight from idle; a column-finishing
// pixel holds off further input while its column is added and, from column k on, the median
// walked, the result issued (waiting for a free output register) and the oldest column removed.
// A column add or removal passes ring read, histogram read and write per pixel; a median step
// is a check and a finish state. The end-of-line beat adds k further add, walk, issue and remove rounds.
// Reset is synchronous, active low; the histogram clears at once through per-bin valid bits.
module running_histogram_median_line #(
  parameter int MAX_HALF_WINDOW = rhm_pkg::DEF_MAX_HALF_WINDOW,
  parameter int MAX_LINE_WIDTH  = rhm_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rhm_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_end_of_line,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhm_pkg::PIX_W-1:0] out_median_value,
  output logic [rhm_pkg::COL_W-1:0] out_column,
  output logic                      out_line_done,
  output logic                      out_short_line_error,
  input  logic                      cfg_we,
  input  logic [rhm_pkg::HW_W-1:0]  cfg_wdata
);

  rhm_pkg::cmd_t    cmd;
  rhm_pkg::status_t st;

  rhm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_line (in_end_of_line),
    .in_ready       (in_ready),
    .st             (st),
    .cmd            (cmd)
  );

  rhm_dp #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .MAX_LINE_WIDTH  (MAX_LINE_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_pixel             (in_pixel),
    .in_end_of_line       (in_end_of_line),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_median_value     (out_median_value),
    .out_column           (out_column),
    .out_line_done        (out_line_done),
    .out_short_line_error (out_short_line_error),
    .cmd                  (cmd),
    .st                   (st)
  );

`ifndef SYNTHESIS
  // A result beat is only loaded into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_med || cmd.emit_err) |-> st.out_free)
    else $error("result loaded into an occupied output register");

  a_err_short: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_err |-> st.cols_short)
    else $error("short line error raised on a long enough line");

  a_up_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.up_step |=> cmd.up_fin)
    else $error("upward median step not followed by its count update");
`endif

endmodule

/* hdl/rhm_ctrl.sv */
// Sequencer for column add, median walk, result issue, column removal and line flush.
module rhm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_end_of_line,
  output logic             in_ready,
  input  rhm_pkg::status_t st,
  output rhm_pkg::cmd_t    cmd
);

  rhm_pkg::state_t state_r, state_nxt;
  rhm_pkg::mode_t  mode_r, mode_nxt;
  logic            op_rem_r, op_rem_nxt;
  logic            flush_r, flush_nxt;
  logic            eol_r, eol_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rhm_pkg::S_IDLE;
      mode_r   <= rhm_pkg::MODE_ADD;
      op_rem_r <= 1'b0;
      flush_r  <= 1'b0;
      eol_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      op_rem_r <= op_rem_nxt;
      flush_r  <= flush_nxt;
      eol_r    <= eol_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    op_rem_nxt = op_rem_r;
    flush_nxt  = flush_r;
    eol_nxt    = eol_r;
    case (state_r)
      rhm_pkg::S_IDLE: begin
        if (in_valid && st.complete) begin
          mode_nxt   = st.c_lt_k ? rhm_pkg::MODE_ADD : rhm_pkg::MODE_PROD;
          op_rem_nxt = 1'b0;
          flush_nxt  = 1'b0;
          eol_nxt    = in_end_of_line;
          state_nxt  = rhm_pkg::S_PR;
        end else if (in_valid && in_end_of_line) begin
          state_nxt = rhm_pkg::S_EOL;
        end
      end
      rhm_pkg::S_PR: state_nxt = rhm_pkg::S_PH;
      rhm_pkg::S_PH: state_nxt = rhm_pkg::S_PW;
      rhm_pkg::S_PW: begin
        if (!st.last_row) begin
          state_nxt = rhm_pkg::S_PR;
        end else if (op_rem_r) begin
          state_nxt = flush_r ? rhm_pkg::S_FLNEXT : rhm_pkg::S_COLDONE;
        end else if (mode_r == rhm_pkg::MODE_ADD) begin
          state_nxt = st.rep_zero ? rhm_pkg::S_COLDONE : rhm_pkg::S_PR;
        end else begin
          state_nxt = rhm_pkg::S_WRD;
        end
      end
      rhm_pkg::S_WRD: state_nxt = rhm_pkg::S_WUC;
      rhm_pkg::S_WUC: state_nxt = st.up_go ? rhm_pkg::S_WUF : rhm_pkg::S_WDC;
      rhm_pkg::S_WUF: state_nxt = rhm_pkg::S_WUC;
      rhm_pkg::S_WDC: state_nxt = st.dn_go ? rhm_pkg::S_WDF : rhm_pkg::S_EMIT;
      rhm_pkg::S_WDF: state_nxt = rhm_pkg::S_WDC;
      rhm_pkg::S_EMIT: begin
        if (st.out_free) begin
          op_rem_nxt = 1'b1;
          state_nxt  = rhm_pkg::S_PR;
        end
      end
      rhm_pkg::S_COLDONE: state_nxt = eol_r ? rhm_pkg::S_EOL : rhm_pkg::S_IDLE;
      rhm_pkg::S_EOL: begin
        if (st.cols_short) begin
          state_nxt = rhm_pkg::S_ERR;
        end else begin
          flush_nxt  = 1'b1;
          op_rem_nxt = 1'b0;
          mode_nxt   = rhm_pkg::MODE_PROD;
          state_nxt  = st.k_zero ? rhm_pkg::S_CLEAR : rhm_pkg::S_PR;
        end
      end
      rhm_pkg::S_FLNEXT: begin
        if (st.flush_last) begin
          state_nxt = rhm_pkg::S_CLEAR;
        end else begin
          op_rem_nxt = 1'b0;
          state_nxt  = rhm_pkg::S_PR;
        end
      end
      rhm_pkg::S_ERR: begin
        if (st.out_free) begin
          state_nxt = rhm_pkg::S_CLEAR;
        end
      end
      rhm_pkg::S_CLEAR: state_nxt = rhm_pkg::S_IDLE;
      default: state_nxt = rhm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cmd.op_rem = op_rem_r;
    case (state_r)
      rhm_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.accept    = in_valid;
        cmd.setup_col = in_valid && st.complete;
      end
      rhm_pkg::S_PR: cmd.ring_rd = 1'b1;
      rhm_pkg::S_PH: cmd.hist_rd = 1'b1;
      rhm_pkg::S_PW: begin
        cmd.pix_wr  = 1'b1;
        cmd.rep_dec = st.last_row && !op_rem_r && (mode_r == rhm_pkg::MODE_ADD) &&
                      !st.rep_zero;
      end
      rhm_pkg::S_WRD: cmd.walk_rd = 1'b1;
      rhm_pkg::S_WUC: cmd.up_step = st.up_go;
      rhm_pkg::S_WUF: cmd.up_fin = 1'b1;
      rhm_pkg::S_WDC: cmd.dn_step = st.dn_go;
      rhm_pkg::S_WDF: cmd.dn_fin = 1'b1;
      rhm_pkg::S_EMIT: begin
        cmd.emit_med  = st.out_free;
        // The last beat of a line is the final flush result, or the only one when k is zero.
        cmd.line_done = flush_r ? st.flush_last : (eol_r && st.k_zero);
      end
      rhm_pkg::S_COLDONE: cmd.col_done = 1'b1;
      rhm_pkg::S_EOL: cmd.setup_flush = !st.cols_short;
      rhm_pkg::S_FLNEXT: cmd.flush_next = !st.flush_last;
      rhm_pkg::S_ERR: cmd.emit_err = st.out_free;
      rhm_pkg::S_CLEAR: cmd.clear = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* hdl/rhm_dp.sv */
// Datapath: column ring, histogram with per-bin valid bits, median walk and output register.
module rhm_dp #(
  parameter int MAX_HALF_WINDOW = rhm_pkg::DEF_MAX_HALF_WINDOW,
  parameter int MAX_LINE_WIDTH  = rhm_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rhm_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_end_of_line,
  input  logic                      cfg_we,
  input  logic [rhm_pkg::HW_W-1:0]  cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhm_pkg::PIX_W-1:0] out_median_value,
  output logic [rhm_pkg::COL_W-1:0] out_column,
  output logic                      out_line_done,
  output logic                      out_short_line_error,
  input  rhm_pkg::cmd_t             cmd,
  output rhm_pkg::status_t          st
);

  localparam int RING = 2 * MAX_HALF_WINDOW + 1;
  localparam int RW   = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int KW   = $clog2(MAX_HALF_WINDOW + 2);
  localparam int AW   = $clog2(RING * RING + 1);
  localparam int CW   = $clog2(RING * RING + 1);
  localparam int ICW  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int PW   = rhm_pkg::PIX_W;
  localparam int BW   = $clog2(rhm_pkg::NUM_BINS);

  logic [rhm_pkg::HW_W-1:0] k_r, k_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [ICW-1:0] incol_r, incol_nxt;
  logic [RW-1:0]  slot_r, slot_nxt;
  logic [rhm_pkg::COL_W-1:0] outcol_r, outcol_nxt;
  logic [PW-1:0]  median_r, median_nxt;
  logic [CW-1:0]  below_r, below_nxt;
  logic [CW-1:0]  above_r, above_nxt;
  logic [RW-1:0]  add_slot_r, add_slot_nxt;
  logic [RW-1:0]  rem_slot_r, rem_slot_nxt;
  logic signed [ICW:0] rem_num_r, rem_num_nxt;
  logic [KW-1:0]  rep_r, rep_nxt;
  logic [KW-1:0]  ft_r, ft_nxt;
  logic [RW-1:0]  opr_r, opr_nxt;

  logic [PW-1:0]  ring_mem_r [RING*RING];
  logic [PW-1:0]  ring_q_r;
  logic [CW-1:0]  hist_mem_r [rhm_pkg::NUM_BINS];
  logic [CW-1:0]  hist_q_r;
  logic [BW-1:0]  hist_addr_r;
  logic [rhm_pkg::NUM_BINS-1:0] hvalid_r;

  logic [KW-1:0]  k_eff;
  logic [RW-1:0]  twok;
  logic [RW-1:0]  slot_m2k, slot_m1, slot_inc, rem_slot_inc, cur_slot;
  logic [RW:0]    slot_wrap;
  logic           incol_lt_max, row_last;
  logic           ring_we;
  logic [AW-1:0]  ring_waddr, ring_raddr;
  logic           hist_re, hist_we;
  logic [BW-1:0]  hist_rd_addr;
  logic [CW-1:0]  hist_val, hist_new;
  logic [CW:0]    up_sum, dn_sum;
  logic           v_gt, v_lt;

  assign k_eff = (int'(k_r) > MAX_HALF_WINDOW) ? KW'(MAX_HALF_WINDOW) : KW'(k_r);
  assign twok  = RW'(2 * int'(k_eff));

  assign incol_lt_max = incol_r < ICW'(MAX_LINE_WIDTH);
  assign row_last     = row_r == twok;

  // Ring slot of the column 2k behind the next one, taken modulo the ring size.
  assign slot_wrap = {1'b0, slot_r} + (RW + 1)'(RING) - {1'b0, twok};
  assign slot_m2k  = (slot_r >= twok) ? (slot_r - twok) : RW'(slot_wrap);
  assign slot_m1   = (slot_r == '0) ? RW'(RING - 1) : (slot_r - RW'(1));
  assign slot_inc  = (slot_r == RW'(RING - 1)) ? '0 : (slot_r + RW'(1));
  assign rem_slot_inc = (rem_slot_r == RW'(RING - 1)) ? '0 : (rem_slot_r + RW'(1));

  // Removing a column before the left edge means removing the replicated column zero.
  assign cur_slot = cmd.op_rem ? (rem_num_r[ICW] ? '0 : rem_slot_r) : add_slot_r;

  assign ring_we    = cmd.accept && incol_lt_max && (row_last || !in_end_of_line);
  assign ring_waddr = AW'(int'(slot_r) * RING + int'(row_r));
  assign ring_raddr = AW'(int'(cur_slot) * RING + int'(opr_r));

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem_r[ring_waddr] <= in_pixel;
    end
    if (cmd.ring_rd) begin
      ring_q_r <= ring_mem_r[ring_raddr];
    end
  end

  assign hist_val = hvalid_r[hist_addr_r] ? hist_q_r : '0;
  assign v_gt     = hist_addr_r > median_r;
  assign v_lt     = hist_addr_r < median_r;
  assign up_sum   = {1'b0, hist_val} + {1'b0, below_r};
  assign dn_sum   = {1'b0, hist_val} + {1'b0, above_r};

  assign hist_re = cmd.hist_rd || cmd.walk_rd || cmd.up_step || cmd.dn_step;
  assign hist_we = cmd.pix_wr;

  always_comb begin
    hist_rd_addr = median_r;
    if (cmd.hist_rd) begin
      hist_rd_addr = ring_q_r;
    end else if (cmd.up_step) begin
      hist_rd_addr = median_r + BW'(1);
    end else if (cmd.dn_step) begin
      hist_rd_addr = median_r - BW'(1);
    end
  end

  always_comb begin
    if (cmd.op_rem) begin
      hist_new = (hist_val != '0) ? (hist_val - CW'(1)) : hist_val;
    end else begin
      hist_new = hist_val + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem_r[hist_addr_r] <= hist_new;
    end
    if (hist_re) begin
      hist_q_r    <= hist_mem_r[hist_rd_addr];
      hist_addr_r <= hist_rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || cmd.clear) begin
      hvalid_r <= '0;
    end else if (hist_we) begin
      hvalid_r[hist_addr_r] <= 1'b1;
    end
  end

  always_comb begin
    k_nxt        = k_r;
    row_nxt      = row_r;
    incol_nxt    = incol_r;
    slot_nxt     = slot_r;
    outcol_nxt   = outcol_r;
    median_nxt   = median_r;
    below_nxt    = below_r;
    above_nxt    = above_r;
    add_slot_nxt = add_slot_r;
    rem_slot_nxt = rem_slot_r;
    rem_num_nxt  = rem_num_r;
    rep_nxt      = rep_r;
    ft_nxt       = ft_r;
    opr_nxt      = opr_r;

    if (cmd.accept && incol_lt_max) begin
      if (row_last) begin
        row_nxt = '0;
      end else if (!in_end_of_line) begin
        row_nxt = row_r + RW'(1);
      end
    end

    if (cmd.setup_col || cmd.setup_flush) begin
      add_slot_nxt = cmd.setup_flush ? slot_m1 : slot_r;
      rem_slot_nxt = slot_m2k;
      rem_num_nxt  = $signed({1'b0, incol_r}) - $signed((ICW + 1)'(twok));
      rep_nxt      = (incol_r == '0) ? k_eff : '0;
      ft_nxt       = '0;
      opr_nxt      = '0;
    end

    if (cmd.flush_next) begin
      rem_num_nxt  = rem_num_r + (ICW + 1)'(1);
      rem_slot_nxt = rem_slot_inc;
      ft_nxt       = ft_r + KW'(1);
    end

    if (cmd.col_done) begin
      incol_nxt = incol_r + ICW'(1);
      slot_nxt  = slot_inc;
    end

    if (cmd.pix_wr) begin
      opr_nxt = (opr_r == twok) ? '0 : (opr_r + RW'(1));
      if (cmd.op_rem) begin
        if (v_gt && above_r != '0) begin
          above_nxt = above_r - CW'(1);
        end else if (v_lt && below_r != '0) begin
          below_nxt = below_r - CW'(1);
        end
      end else begin
        if (v_gt) begin
          above_nxt = above_r + CW'(1);
        end else if (v_lt) begin
          below_nxt = below_r + CW'(1);
        end
      end
    end

    if (cmd.rep_dec) begin
      rep_nxt = rep_r - KW'(1);
    end

    if (cmd.up_step) begin
      below_nxt  = CW'(up_sum);
      median_nxt = median_r + PW'(1);
    end
    if (cmd.up_fin) begin
      above_nxt = (above_r >= hist_val) ? (above_r - hist_val) : '0;
    end
    if (cmd.dn_step) begin
      above_nxt  = CW'(dn_sum);
      median_nxt = median_r - PW'(1);
    end
    if (cmd.dn_fin) begin
      below_nxt = (below_r >= hist_val) ? (below_r - hist_val) : '0;
    end

    if (cmd.emit_med) begin
      outcol_nxt = outcol_r + rhm_pkg::COL_W'(1);
    end

    if (cfg_we) begin
      k_nxt = cfg_wdata;
    end
    if (cfg_we || cmd.clear) begin
      row_nxt    = '0;
      incol_nxt  = '0;
      slot_nxt   = '0;
      outcol_nxt = '0;
      median_nxt = '0;
      below_nxt  = '0;
      above_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= rhm_pkg::HW_RESET;
      row_r    <= '0;
      incol_r  <= '0;
      slot_r   <= '0;
      outcol_r <= '0;
      median_r <= '0;
      below_r  <= '0;
      above_r  <= '0;
      rep_r    <= '0;
      ft_r     <= '0;
      opr_r    <= '0;
    end else begin
      k_r      <= k_nxt;
      row_r    <= row_nxt;
      incol_r  <= incol_nxt;
      slot_r   <= slot_nxt;
      outcol_r <= outcol_nxt;
      median_r <= median_nxt;
      below_r  <= below_nxt;
      above_r  <= above_nxt;
      rep_r    <= rep_nxt;
      ft_r     <= ft_nxt;
      opr_r    <= opr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_slot_r <= add_slot_nxt;
    rem_slot_r <= rem_slot_nxt;
    rem_num_r  <= rem_num_nxt;
  end

  // Output register: loaded only when empty or being drained in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_med || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_med) begin
      out_median_value     <= median_r;
      out_column           <= outcol_r;
      out_line_done        <= cmd.line_done;
      out_short_line_error <= 1'b0;
    end else if (cmd.emit_err) begin
      out_median_value     <= '0;
      out_column           <= '0;
      out_line_done        <= 1'b1;
      out_short_line_error <= 1'b1;
    end
  end

  assign st.complete   = incol_lt_max && row_last;
  assign st.c_lt_k     = incol_r < ICW'(k_eff);
  assign st.last_row   = opr_r == twok;
  assign st.rep_zero   = rep_r == '0;
  assign st.up_go      = (median_r != {PW{1'b1}}) && ({1'b0, above_r} > up_sum);
  assign st.dn_go      = (median_r != '0) && ({1'b0, below_r} > dn_sum);
  assign st.out_free   = !out_valid || out_ready;
  assign st.cols_short = incol_r <= ICW'(k_eff);
  assign st.k_zero     = k_eff == '0;
  assign st.flush_last = (ft_r + KW'(1)) == k_eff;

endmodule

/* sim/running_histogram_median_line_tb.sv */
// Testbench for the running histogram median line: random band lines checked against a predictor.
`timescale 1ns / 100ps

module running_histogram_median_line_tb;

  localparam int MAXK      = 7;
  localparam int MAXW      = 4096;
  localparam int RING      = 2 * MAXK + 1;
  localparam int IDLE_WAIT = 2500;
  localparam int WD_LIMIT  = 20000;

  typedef struct {
    logic [rhm_pkg::PIX_W-1:0] med;
    logic [rhm_pkg::COL_W-1:0] col;
    logic                      done;
    logic                      err;
  } median_beat_t;

  class median_scoreboard;
    median_beat_t expected_medians[$];
    int hist[rhm_pkg::NUM_BINS];
    int ring[RING][RING];
    int k, med, below, above, row, incol, outcol;
    int mismatches, beats_seen, lines_seen;

    function new();
      k = rhm_pkg::HW_RESET;
      mismatches = 0;
      beats_seen = 0;
      lines_seen = 0;
      foreach (ring[i, j]) ring[i][j] = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (hist[i]) hist[i] = 0;
      med = 0; below = 0; above = 0; row = 0; incol = 0; outcol = 0;
    endfunction

    function void set_half_window(logic [rhm_pkg::HW_W-1:0] v);
      k = (v > MAXK) ? MAXK : v;
      clear_line();
    endfunction

    function void push_beat(int m, int c, bit e);
      median_beat_t b;
      b.med = m[rhm_pkg::PIX_W-1:0];
      b.col = c[rhm_pkg::COL_W-1:0];
      b.done = 1'b0;
      b.err = e;
      expected_medians.push_back(b);
    endfunction

    function void column_pass(int c, bit remove);
      int slot, v;
      slot = c % RING;
      for (int r = 0; r <= 2 * k; r++) begin
        v = ring[slot][r];
        if (!remove) begin
          hist[v]++;
          if (v > med) above++;
          else if (v < med) below++;
        end else begin
          if (hist[v] > 0) hist[v]--;
          if (v > med) begin
            if (above > 0) above--;
          end else if (v < med) begin
            if (below > 0) below--;
          end
        end
      end
    endfunction

    function void walk();
      while (med < 255 && above > hist[med] + below) begin
        below += hist[med];
        med++;
        above = (above >= hist[med]) ? above - hist[med] : 0;
      end
      while (med > 0 && below > hist[med] + above) begin
        above += hist[med];
        med--;
        below = (below >= hist[med]) ? below - hist[med] : 0;
      end
    endfunction

    function void produce(int add_col, int rem_col);
      column_pass(add_col, 0);
      walk();
      push_beat(med, outcol, 0);
      outcol++;
      column_pass(rem_col, 1);
    endfunction

    // Works out every result that one accepted input beat causes.
    function void note_pixel(logic [rhm_pkg::PIX_W-1:0] pix, logic eol);
      int n0, cols;
      n0 = expected_medians.size();
      if (row > 2 * k) row = 0;
      if (incol < MAXW) begin
        if (row == 2 * k) begin
          ring[incol % RING][row] = pix;
          row = 0;
          if (incol < k) begin
            for (int t = 0; t < ((incol == 0) ? k + 1 : 1); t++) column_pass(incol, 0);
          end else begin
            produce(incol, (incol >= 2 * k) ? incol - 2 * k : 0);
          end
          incol++;
        end else if (!eol) begin
          ring[incol % RING][row] = pix;
          row++;
        end
      end
      if (eol) begin
        cols = incol;
        if (cols < k + 1) push_beat(0, 0, 1);
        else
          for (int i = cols - k; i < cols; i++) produce(cols - 1, (i >= k) ? i - k : 0);
        if (expected_medians.size() > n0)
          expected_medians[expected_medians.size() - 1].done = 1'b1;
        lines_seen++;
        clear_line();
      end
    endfunction

    function void check_result(logic [rhm_pkg::PIX_W-1:0] m, logic [rhm_pkg::COL_W-1:0] c,
                               logic d, logic e);
      median_beat_t x;
      beats_seen++;
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: median %0d column %0d done %0b err %0b", m, c, d, e);
        return;
      end
      x = expected_medians.pop_front();
      if (x.med !== m || x.col !== c || x.done !== d || x.err !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected median %0d col %0d done %0b err %0b, got %0d %0d %0b %0b",
                   x.med, x.col, x.done, x.err, m, c, d, e);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [rhm_pkg::PIX_W-1:0] in_pixel = '0;
  logic                      in_end_of_line = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [rhm_pkg::PIX_W-1:0] out_median_value;
  logic [rhm_pkg::COL_W-1:0] out_column;
  logic                      out_line_done;
  logic                      out_short_line_error;
  logic                      cfg_we = 1'b0;
  logic [rhm_pkg::HW_W-1:0]  cfg_wdata = '0;

  median_scoreboard sb = new();
  int  cur_k = rhm_pkg::HW_RESET;
  int  burst_left = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;
  bit  k_seen[8];

  running_histogram_median_line dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel(in_pixel), .in_end_of_line(in_end_of_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_median_value(out_median_value), .out_column(out_column),
    .out_line_done(out_line_done), .out_short_line_error(out_short_line_error),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_median_value, out_column, out_line_done, out_short_line_error);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: a stall pattern of its own, plus one long hold-off on request.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        phase++;
        if ((phase / 64) % 3 == 0) out_ready = 1'b1;
        else out_ready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_pixel(logic [rhm_pkg::PIX_W-1:0] pix, logic eol);
    if (burst_left == 0) begin
      if (in_valid) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_pixel = pix;
    in_end_of_line = eol;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(pix, eol);
    burst_left--;
    items_sent++;
  endtask

  // Wait for the block to drain fully, then write the half window.
  task automatic write_half_window(logic [rhm_pkg::HW_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.expected_medians.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_half_window(v);
    cur_k = (v > MAXK) ? MAXK : v;
    k_seen[v] = 1'b1;
  endtask

  function automatic logic [rhm_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128 + rhm_pkg::PIX_W'($urandom_range(0, 3));
      default: return rhm_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One band line of ncols columns; cut_row >= 0 ends the line early inside the next column.
  task automatic send_line(int ncols, int cut_row, bit fixed_pix,
                           logic [rhm_pkg::PIX_W-1:0] fpix);
    int rows;
    rows = 2 * cur_k + 1;
    for (int c = 0; c < ncols; c++)
      for (int r = 0; r < rows; r++)
        send_pixel(fixed_pix ? fpix : rand_pixel(),
                   (cut_row < 0) && (c == ncols - 1) && (r == rows - 1));
    if (cut_row >= 0) begin
      for (int r = 0; r < cut_row; r++) send_pixel(rand_pixel(), 1'b0);
      send_pixel(rand_pixel(), 1'b1);
    end
  endtask

  initial begin
    int kv, w, start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset half window of one, short lines, a cut column and pixel extremes.
    send_line(1, -1, 1, 8'd255);
    send_line(2, -1, 1, 8'd0);
    send_line(0, 0, 0, 0);
    send_line(2, 1, 0, 0);
    send_line(3, -1, 0, 0);
    write_half_window(3'd0);
    send_line(1, -1, 1, 8'd255);
    send_line(4, -1, 0, 0);
    write_half_window(3'd7);
    send_line(8, -1, 0, 0);

    // A partial line is discarded by the register write that follows it.
    write_half_window(3'd2);
    send_pixel(8'd17, 1'b0);
    send_pixel(8'd200, 1'b0);

    start = items_sent;
    while (items_sent - start < 40) begin
      kv = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) kv = ($urandom_range(0, 1) != 0) ? 7 : 0;
      write_half_window(kv[rhm_pkg::HW_W-1:0]);
      repeat ($urandom_range(1, 3)) begin
        w = (cur_k >= 5) ? $urandom_range(1, 6) : $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0: send_line($urandom_range(0, cur_k), -1, 0, 0);
          1: if (cur_k > 0) send_line(w, $urandom_range(0, 2 * cur_k - 1), 0, 0);
             else send_line(w, -1, 0, 0);
          default: send_line(w, -1, ($urandom_range(0, 7) == 0), rand_pixel());
        endcase
      end
    end

    // Long receiver hold-off while a line keeps arriving.
    write_half_window(3'd1);
    hold_req = 1'b1;
    send_line(10, -1, 0, 0);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_medians.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);

    $display("Covered %0d input beats, %0d lines and %0d result beats.",
             items_sent, sb.lines_seen, sb.beats_seen);
    $display("Half windows 0..7 written: %0b%0b%0b%0b%0b%0b%0b%0b; %0d mismatches.",
             k_seen[0], k_seen[1], k_seen[2], k_seen[3], k_seen[4], k_seen[5], k_seen[6],
             k_seen[7], sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_medians.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
